@@ sv/sipm_desaturation_energy_macros.svh @@
`ifndef SIPM_DESATURATION_ENERGY_MACROS_SVH
`define SIPM_DESATURATION_ENERGY_MACROS_SVH

// same-cycle implication, held off while in reset
`define SDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off while in reset
`define SDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/sde_pkg.sv @@
package sde_pkg;

  localparam int E_W     = 22;
  localparam int CAL_W   = 24;
  localparam int N_W     = 16;
  localparam int PPM_W   = 16;
  localparam int EN_W    = 32;
  localparam int A_W     = 20;                 // 16*N
  localparam int MANT_W  = 31;                 // Q1.30
  localparam int FRAC_W  = 24;                 // log2 fraction bits, one per cell
  localparam int K_W     = 5;
  localparam int LOG_W   = K_W + FRAC_W;       // Q5.24
  localparam int D_W     = 48;                 // desaturated amplitude, Q.24
  localparam int T_W     = D_W + 8;            // dividend and quotient
  localparam int LOG_STEPS = FRAC_W;
  localparam int DIV_STEPS = T_W;

  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [25:0] LN20_Q24 = 26'd50260047;

  localparam logic [N_W-1:0]   PIXEL_COUNT_RST = 16'd10000;
  localparam logic [PPM_W-1:0] PE_PER_MIP_RST  = 16'd2560;

  typedef enum logic [0:0] {
    REG_PIXEL_COUNT = 1'b0,
    REG_PE_PER_MIP  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [K_W-1:0]    k;
    logic [MANT_W-1:0] m;
  } norm_t;

  typedef struct packed {
    logic [E_W-1:0]    e;
    logic [CAL_W-1:0]  cal;
    logic              lin;
    logic [K_W-1:0]    ka;
    logic [K_W-1:0]    kb;
    logic [MANT_W-1:0] ma;
    logic [MANT_W-1:0] mb;
    logic [FRAC_W-1:0] fa;
    logic [FRAC_W-1:0] fb;
  } log_item_t;

  typedef struct packed {
    logic [T_W-1:0]   x;     // dividend bits in, quotient bits out
    logic [PPM_W-1:0] rem;
    logic [CAL_W-1:0] cal;
    logic             lin;
  } div_item_t;

  // integer part of log2 and mantissa normalized to Q1.30
  function automatic norm_t log2_norm(input logic [A_W-1:0] v);
    norm_t r;
    logic [K_W-1:0] k;
    logic [MANT_W-1:0] w;
    k = '0;
    for (int i = 0; i < A_W; i++) begin
      if (v[i]) k = K_W'(i);
    end
    w = MANT_W'(v);
    r.k = k;
    r.m = w << (K_W'(MANT_W - 1) - k);
    return r;
  endfunction

endpackage

@@ sv/sde_log_cell.sv @@
module sde_log_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  sde_pkg::log_item_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output sde_pkg::log_item_t dn_data
);
  import sde_pkg::*;

  logic      dn_valid_r;
  log_item_t dn_data_r;
  log_item_t dn_data_nxt;

  logic [2*MANT_W-1:0] sq_a;
  logic [2*MANT_W-1:0] sq_b;
  logic [MANT_W:0]     ta;
  logic [MANT_W:0]     tb;

  // one fraction bit of log2 per cell: square, renormalize
  always_comb begin
    sq_a = (2*MANT_W)'(up_data.ma) * (2*MANT_W)'(up_data.ma);
    sq_b = (2*MANT_W)'(up_data.mb) * (2*MANT_W)'(up_data.mb);
    ta   = sq_a[2*MANT_W-1:MANT_W-1];
    tb   = sq_b[2*MANT_W-1:MANT_W-1];
    dn_data_nxt    = up_data;
    dn_data_nxt.ma = ta[MANT_W] ? ta[MANT_W:1] : ta[MANT_W-1:0];
    dn_data_nxt.mb = tb[MANT_W] ? tb[MANT_W:1] : tb[MANT_W-1:0];
    dn_data_nxt.fa = {up_data.fa[FRAC_W-2:0], ta[MANT_W]};
    dn_data_nxt.fb = {up_data.fb[FRAC_W-2:0], tb[MANT_W]};
  end

  assign up_ready = !dn_valid_r || dn_ready;
  assign dn_valid = dn_valid_r;
  assign dn_data  = dn_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_valid_r <= 1'b0;
    end else if (up_ready) begin
      dn_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data_r <= dn_data_nxt;
    end
  end

endmodule

@@ sv/sde_div_cell.sv @@
module sde_div_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [sde_pkg::PPM_W-1:0] divisor,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  sde_pkg::div_item_t        up_data,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output sde_pkg::div_item_t        dn_data
);
  import sde_pkg::*;

  logic      dn_valid_r;
  div_item_t dn_data_r;
  div_item_t dn_data_nxt;

  logic [PPM_W:0] r2;
  logic [PPM_W:0] r2_sub;
  logic           ge;

  // restoring division, one quotient bit per cell
  always_comb begin
    r2     = {up_data.rem, up_data.x[T_W-1]};
    r2_sub = r2 - {1'b0, divisor};
    ge     = r2 >= {1'b0, divisor};
    dn_data_nxt     = up_data;
    dn_data_nxt.rem = ge ? r2_sub[PPM_W-1:0] : r2[PPM_W-1:0];
    dn_data_nxt.x   = {up_data.x[T_W-2:0], ge};
  end

  assign up_ready = !dn_valid_r || dn_ready;
  assign dn_valid = dn_valid_r;
  assign dn_data  = dn_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_valid_r <= 1'b0;
    end else if (up_ready) begin
      dn_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data_r <= dn_data_nxt;
    end
  end

endmodule

@@ sv/sipm_desaturation_energy.sv @@
// Photodetector saturation correction: each hit amplitude E is desaturated
// as -N*ln(1-E/(16N)) below 0.95*16N and by its linear continuation above,
// divided by pe_per_mip and scaled by the hit's calibration factor into
// Q16.16 energy, clipped with an overflow flag. One hit per clock is accepted
// unless a stalled output has backed the pipeline up to the input. The
// pipeline has one normalize stage, 24 squaring cells for the two log2 values,
// three stages for the log difference and desaturation, 56 cells of the
// bit-per-cell divider and two stages for the calibration product. Every stage
// holds its item on its own, so a stalled output only backs up the pipeline as
// it fills. Write pixel_count and pe_per_mip only while no hit is in flight; a pe_per_mip of zero acts as one.
`include "sipm_desaturation_energy_macros.svh"

module sipm_desaturation_energy (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sde_pkg::E_W-1:0]   in_pe_amplitude,
  input  logic [sde_pkg::CAL_W-1:0] in_calib_factor,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sde_pkg::EN_W-1:0]  out_energy,
  output logic                      out_linear_region,
  output logic                      out_overflow,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  sde_pkg::cfg_reg_t         cfg_index,
  input  logic [15:0]               cfg_data
);
  import sde_pkg::*;

  // configuration
  logic [N_W-1:0]   n_r;
  logic [PPM_W-1:0] ppm_r;
  logic [PPM_W-1:0] ppm_eff;

  assign cfg_ready = 1'b1;
  assign ppm_eff   = (ppm_r == '0) ? PPM_W'(1) : ppm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= PIXEL_COUNT_RST;
      ppm_r <= PE_PER_MIP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PIXEL_COUNT: n_r   <= cfg_data;
        REG_PE_PER_MIP:  ppm_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: threshold test and log2 normalization of 16N and 16N-E
  logic      v_f_r;
  log_item_t f_r;
  logic      rdy_f;
  logic [A_W-1:0] a_in;
  logic [E_W-1:0] b_full;
  norm_t     na;
  norm_t     nb;
  logic      lin_in;

  logic      lc_valid [0:LOG_STEPS];
  logic      lc_ready [0:LOG_STEPS];
  log_item_t lc_data  [0:LOG_STEPS];

  always_comb begin
    a_in   = {n_r, 4'b0};
    b_full = E_W'(a_in) - in_pe_amplitude;
    na     = log2_norm(a_in);
    nb     = log2_norm(b_full[A_W-1:0]);
    lin_in = (27'(in_pe_amplitude) * 27'd20) >= (27'(n_r) * 27'd304);
  end

  assign rdy_f    = !v_f_r || lc_ready[0];
  assign in_ready = rdy_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
    end else if (rdy_f) begin
      v_f_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f && in_valid) begin
      f_r.e   <= in_pe_amplitude;
      f_r.cal <= in_calib_factor;
      f_r.lin <= lin_in;
      f_r.ka  <= na.k;
      f_r.kb  <= nb.k;
      f_r.ma  <= na.m;
      f_r.mb  <= nb.m;
      f_r.fa  <= '0;
      f_r.fb  <= '0;
    end
  end

  assign lc_valid[0] = v_f_r;
  assign lc_data[0]  = f_r;

  for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
    sde_log_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (lc_valid[j]),
      .up_ready (lc_ready[j]),
      .up_data  (lc_data[j]),
      .dn_valid (lc_valid[j+1]),
      .dn_ready (lc_ready[j+1]),
      .dn_data  (lc_data[j+1])
    );
  end

  // L1: log2(a) - log2(b)
  logic             v_l1_r;
  logic             rdy_l1;
  logic [LOG_W-1:0] diff_r;
  logic [E_W-1:0]   e_l1_r;
  logic [CAL_W-1:0] cal_l1_r;
  logic             lin_l1_r;
  log_item_t        lt;

  assign lt                 = lc_data[LOG_STEPS];
  assign lc_ready[LOG_STEPS] = rdy_l1;

  // L2: times ln2
  logic             v_l2_r;
  logic             rdy_l2;
  logic [LOG_W-1:0] nat_r;
  logic [E_W-1:0]   e_l2_r;
  logic [CAL_W-1:0] cal_l2_r;
  logic             lin_l2_r;
  logic [LOG_W+31:0] nat_prod;

  // L3: desaturated amplitude, loaded as the divider's first item
  logic      v_l3_r;
  logic      rdy_l3;
  div_item_t l3_r;
  logic [D_W-1:0] d_lin;
  logic [D_W-1:0] d_log;

  logic      dc_valid [0:DIV_STEPS];
  logic      dc_ready [0:DIV_STEPS];
  div_item_t dc_data  [0:DIV_STEPS];

  assign rdy_l1 = !v_l1_r || rdy_l2;
  assign rdy_l2 = !v_l2_r || rdy_l3;
  assign rdy_l3 = !v_l3_r || dc_ready[0];

  assign nat_prod = (LOG_W+32)'(diff_r) * (LOG_W+32)'(LN2_Q32);

  always_comb begin
    d_lin = ((D_W'(e_l2_r) * D_W'(20)) << 20)
          + D_W'(n_r) * D_W'(LN20_Q24)
          - ((D_W'(n_r) * D_W'(19)) << 24);
    d_log = D_W'(n_r) * D_W'(nat_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_l1_r <= 1'b0;
      v_l2_r <= 1'b0;
      v_l3_r <= 1'b0;
    end else begin
      if (rdy_l1) v_l1_r <= lc_valid[LOG_STEPS];
      if (rdy_l2) v_l2_r <= v_l1_r;
      if (rdy_l3) v_l3_r <= v_l2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_l1 && lc_valid[LOG_STEPS]) begin
      diff_r   <= {lt.ka, lt.fa} - {lt.kb, lt.fb};
      e_l1_r   <= lt.e;
      cal_l1_r <= lt.cal;
      lin_l1_r <= lt.lin;
    end
    if (rdy_l2 && v_l1_r) begin
      nat_r    <= nat_prod[LOG_W+31:32];
      e_l2_r   <= e_l1_r;
      cal_l2_r <= cal_l1_r;
      lin_l2_r <= lin_l1_r;
    end
    if (rdy_l3 && v_l2_r) begin
      l3_r.x   <= {(lin_l2_r ? d_lin : d_log), 8'b0};
      l3_r.rem <= '0;
      l3_r.cal <= cal_l2_r;
      l3_r.lin <= lin_l2_r;
    end
  end

  assign dc_valid[0] = v_l3_r;
  assign dc_data[0]  = l3_r;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    sde_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .divisor  (ppm_eff),
      .up_valid (dc_valid[j]),
      .up_ready (dc_ready[j]),
      .up_data  (dc_data[j]),
      .dn_valid (dc_valid[j+1]),
      .dn_ready (dc_ready[j+1]),
      .dn_data  (dc_data[j+1])
    );
  end

  // M1: split calibration product, M2: recombine and clip (output register)
  logic      v_m1_r;
  logic      rdy_m1;
  logic [47:0] ph_r;
  logic [55:0] pl_r;
  logic        lin_m1_r;
  div_item_t   dt;

  logic        v_m2_r;
  logic        rdy_m2;
  logic [EN_W-1:0] energy_r;
  logic        lin_m2_r;
  logic        ovf_r;
  logic [56:0] sum;

  assign dt                  = dc_data[DIV_STEPS];
  assign rdy_m1              = !v_m1_r || rdy_m2;
  assign rdy_m2              = !v_m2_r || out_ready;
  assign dc_ready[DIV_STEPS] = rdy_m1;
  assign sum = 57'({ph_r, 8'b0}) + 57'(pl_r[55:24]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m1_r <= 1'b0;
      v_m2_r <= 1'b0;
    end else begin
      if (rdy_m1) v_m1_r <= dc_valid[DIV_STEPS];
      if (rdy_m2) v_m2_r <= v_m1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m1 && dc_valid[DIV_STEPS]) begin
      ph_r     <= 48'(dt.x[T_W-1:32]) * 48'(dt.cal);
      pl_r     <= 56'(dt.x[31:0]) * 56'(dt.cal);
      lin_m1_r <= dt.lin;
    end
    if (rdy_m2 && v_m1_r) begin
      ovf_r    <= |sum[56:32];
      energy_r <= (|sum[56:32]) ? '1 : sum[31:0];
      lin_m2_r <= lin_m1_r;
    end
  end

  assign out_valid         = v_m2_r;
  assign out_energy        = energy_r;
  assign out_linear_region = lin_m2_r;
  assign out_overflow      = ovf_r;

  `SDE_ASSERT_NOW(a_log_b_nonzero, clk, rst_n, v_f_r && !f_r.lin, f_r.mb[MANT_W-1], "log region with 16N-E of zero")
  `SDE_ASSERT_NOW(a_log_d_width, clk, rst_n, v_l3_r && !l3_r.lin, l3_r.x[T_W-1:T_W-3] == 3'b0, "log region amplitude too wide")
  `SDE_ASSERT_NOW(a_div_rem, clk, rst_n, dc_valid[DIV_STEPS], dt.rem < ppm_eff, "divider remainder not below divisor")
  `SDE_ASSERT_NOW(a_clip, clk, rst_n, out_valid && out_overflow, out_energy == '1, "clipped energy not at maximum")

endmodule

@@ tb/testbench.sv @@
module testbench;
  import sde_pkg::*;

  typedef struct packed {
    logic [EN_W-1:0] energy;
    logic            linear_region;
    logic            overflow;
  } hit_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [E_W-1:0]       in_pe_amplitude;
  logic [CAL_W-1:0]     in_calib_factor;
  logic                 out_valid;
  logic                 out_ready;
  logic [EN_W-1:0]      out_energy;
  logic                 out_linear_region;
  logic                 out_overflow;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index;
  logic [15:0]          cfg_data;

  logic [N_W-1:0]       pixels;
  logic [PPM_W-1:0]     pe_mip;
  hit_result_t          energy_q[$];
  int                   errors;
  int                   hits_sent;
  int                   results_seen;
  int                   linear_seen;
  int                   clipped_seen;
  bit                   gaps_on;
  bit                   stalls_on;
  int                   hold_cycles;

  sipm_desaturation_energy u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pe_amplitude(in_pe_amplitude), .in_calib_factor(in_calib_factor),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_energy(out_energy), .out_linear_region(out_linear_region),
    .out_overflow(out_overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // log2 of v as Q.24, mantissa squared in Q1.30 with truncation
  function automatic longint unsigned log2_fixed(longint unsigned v);
    longint unsigned m;
    longint unsigned acc;
    int k;
    if (v == 0) return 0;
    k = 0;
    while (k < 30 && (v >> (k + 1)) != 0) k++;
    m = v << (30 - k);
    acc = longint'(k) << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        acc = acc | (64'd1 << i);
      end
    end
    return acc;
  endfunction

  function automatic hit_result_t desaturate_energy(logic [E_W-1:0] e, logic [CAL_W-1:0] cal);
    hit_result_t r;
    longint unsigned n, ppm, d, t, hi, lo, res, a, b, diff, nat;
    n = 64'(pixels);
    ppm = (pe_mip == 0) ? 64'd1 : 64'(pe_mip);
    r.linear_region = (20 * longint'(e)) >= (304 * n);
    if (!r.linear_region) begin
      a = n << 4;
      b = a - 64'(e);
      diff = log2_fixed(a) - log2_fixed(b);
      nat = (diff * longint'(LN2_Q32)) >> 32;
      d = n * nat;
    end else begin
      d = ((longint'(e) * 20) << 20) + n * longint'(LN20_Q24) - ((n * 19) << 24);
    end
    t = (d << 8) / ppm;
    hi = t >> 32;
    lo = t & 64'hFFFF_FFFF;
    res = ((hi * 64'(cal)) << 8) + ((lo * 64'(cal)) >> 24);
    r.overflow = res > 64'hFFFF_FFFF;
    r.energy = r.overflow ? 32'hFFFF_FFFF : res[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // transfers on both channels and config writes are tracked at the rising edge
  always @(posedge clk) begin
    hit_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (energy_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_energy), 64'd0);
        end else begin
          want = energy_q.pop_front();
          if (out_energy !== want.energy)
            report_mismatch("energy", 64'(out_energy), 64'(want.energy));
          if (out_linear_region !== want.linear_region)
            report_mismatch("linear_region", 64'(out_linear_region),
                            64'(want.linear_region));
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", 64'(out_overflow), 64'(want.overflow));
          linear_seen += int'(want.linear_region);
          clipped_seen += int'(want.overflow);
        end
      end
      if (in_valid && in_ready) begin
        energy_q.push_back(desaturate_energy(in_pe_amplitude, in_calib_factor));
        hits_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PIXEL_COUNT) pixels = cfg_data;
        else pe_mip = cfg_data;
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int burst;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_hit(logic [E_W-1:0] e, logic [CAL_W-1:0] cal);
    int burst;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      burst = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (burst) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pe_amplitude <= e;
    in_calib_factor <= cal;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (energy_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_curve(logic [15:0] n, logic [15:0] ppm);
    write_reg(REG_PIXEL_COUNT, n);
    write_reg(REG_PE_PER_MIP, ppm);
  endtask

  // amplitude biased around the 0.95*16N knee so both regions get hits
  function automatic logic [E_W-1:0] pick_amplitude();
    int unsigned knee;
    knee = (304 * pixels) / 20;
    case ($urandom_range(0, 3))
      0: return E_W'($urandom);
      1: return E_W'($urandom_range(0, knee > 4194303 ? 4194303 : knee));
      2: return (knee + $urandom_range(0, 64) > 4194303) ? 22'h3FFFFF
                : E_W'(knee + $urandom_range(0, 64));
      default: return (knee < 64) ? E_W'($urandom_range(0, 64))
                                  : E_W'(knee - $urandom_range(0, 64));
    endcase
  endfunction

  task automatic test_directed;
    // reset values, knee edges, zero and full-scale fields
    send_hit('0, '0);
    send_hit('0, '1);
    send_hit(22'd151999, 24'h010000);
    send_hit(22'd152000, 24'h010000);
    send_hit(22'd159999, 24'h010000);
    send_hit('1, '1);
    send_hit('1, 24'h000001);
    send_hit(22'd1, 24'h010000);
    // zero pixel count: always linear
    set_curve(16'd0, 16'd256);
    send_hit('0, 24'h010000);
    send_hit(22'd1000, 24'h010000);
    send_hit('1, '1);
    // zero pe_per_mip acts as one
    set_curve(16'd1, 16'd0);
    send_hit(22'd15, 24'h000100);
    send_hit(22'd16, 24'h000100);
    send_hit('1, '1);
    send_hit(22'd1, 24'h000001);
    // full-scale registers
    set_curve(16'hFFFF, 16'hFFFF);
    send_hit(22'd996151, 24'h010000);
    send_hit(22'd996152, 24'h010000);
    send_hit(22'd1048559, '1);
    send_hit('1, '1);
    send_hit(22'd524288, 24'h800000);
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(0, 3))
          0: set_curve(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
          1: set_curve(16'($urandom_range(1, 400)), 16'($urandom_range(256, 4096)));
          2: set_curve(16'($urandom), 16'($urandom));
          default: set_curve(16'($urandom_range(5000, 65535)), 16'($urandom_range(1, 300)));
        endcase
      end
      send_hit(pick_amplitude(), CAL_W'($urandom));
    end
    drain();
  endtask

  task automatic test_backpressure;
    set_curve(16'd10000, 16'd2560);
    hold_cycles = 300;
    for (int i = 0; i < 200; i++) send_hit(pick_amplitude(), CAL_W'($urandom));
    drain();
  endtask

  task automatic test_streaming(int count);
    gaps_on = 0;
    stalls_on = 0;
    set_curve(16'd4000, 16'd512);
    for (int i = 0; i < count; i++) send_hit(pick_amplitude(), CAL_W'($urandom));
    drain();
  endtask

  initial begin
    errors = 0;
    hits_sent = 0;
    results_seen = 0;
    linear_seen = 0;
    clipped_seen = 0;
    hold_cycles = 0;
    gaps_on = 1;
    stalls_on = 1;
    pixels = PIXEL_COUNT_RST;
    pe_mip = PE_PER_MIP_RST;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pe_amplitude = '0;
    in_calib_factor = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_PIXEL_COUNT;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(1000);
    test_backpressure();
    test_streaming(200);
    repeat (100) @(posedge clk);
    $display("%0d hits and %0d results checked across reset, zero and full-scale settings",
             hits_sent, results_seen);
    $display("%0d in the linear region, %0d clipped, with stalls and a long hold-off",
             linear_seen, clipped_seen);
    if (errors == 0 && energy_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout");
    $display("testbench NOT OK");
    $finish;
  end

endmodule
